FILE: rtl/three_axis_pid_inertia_moment_core_assert.svh
// ----------------------------------------------------------------------------
// three axis pid inertia moment core - assertion macros
// shared property shapes for the concurrent checks of the core
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_PID_INERTIA_MOMENT_CORE_ASSERT_SVH
`define THREE_AXIS_PID_INERTIA_MOMENT_CORE_ASSERT_SVH

// same-cycle implication
`define TAPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tapm assertion failed");

// next-cycle implication
`define TAPM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tapm assertion failed");

`endif

FILE: rtl/tapm_pkg.sv
// ----------------------------------------------------------------------------
// tapm_pkg
// types and constants shared by the three axis pid inertia moment core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tapm_pkg;

    localparam int N_AXES    = 3;
    localparam int ERR_FRAC  = 15;
    // width of p, i, d terms and their sum before saturation
    localparam int PID_W     = 36;
    // width of the shared multiplier product and the row accumulator
    localparam int MAC_W     = 66;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN_RATE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LOW       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_HIGH      = 3'd4;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_INT,
        PH_PROP,
        PH_DER,
        PH_SUM,
        PH_ROW0,
        PH_ROW1,
        PH_ROW2,
        PH_FIN
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   load;
        logic   commit;
    } t_lane_ctl;

endpackage

`default_nettype wire

FILE: rtl/tapm_seq.sv
// ----------------------------------------------------------------------------
// tapm_seq
// phase sequencer: steps every lane through pid and matrix row phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tapm_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_take,
    output tapm_pkg::t_phase       o_phase,
    output logic                   o_load,
    output logic                   o_in_stall
);

    tapm_pkg::t_phase r_state;
    tapm_pkg::t_phase n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tapm_pkg::PH_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_load     = 1'b0;
        o_in_stall = 1'b1;
        case (r_state)
            tapm_pkg::PH_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_load  = 1'b1;
                    n_state = tapm_pkg::PH_INT;
                end
            end
            tapm_pkg::PH_INT:  n_state = tapm_pkg::PH_PROP;
            tapm_pkg::PH_PROP: n_state = tapm_pkg::PH_DER;
            tapm_pkg::PH_DER:  n_state = tapm_pkg::PH_SUM;
            tapm_pkg::PH_SUM:  n_state = tapm_pkg::PH_ROW0;
            tapm_pkg::PH_ROW0: n_state = tapm_pkg::PH_ROW1;
            tapm_pkg::PH_ROW1: n_state = tapm_pkg::PH_ROW2;
            tapm_pkg::PH_ROW2: n_state = tapm_pkg::PH_FIN;
            tapm_pkg::PH_FIN: begin
                // hold until the output register takes the moments
                if (i_take) begin
                    n_state = tapm_pkg::PH_IDLE;
                end
            end
            default: n_state = tapm_pkg::PH_IDLE;
        endcase
    end

    assign o_phase = r_state;

endmodule

`default_nettype wire

FILE: rtl/tapm_lane.sv
// ----------------------------------------------------------------------------
// tapm_lane
// one axis: pid terms, integrator, last error, then one row of the
// inertia product, all through one registered multiplier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tapm_lane #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire tapm_pkg::t_lane_ctl   i_ctl,
    input  wire logic [31:0]           i_prop_gain,
    input  wire logic [31:0]           i_integ_gain_step,
    input  wire logic [31:0]           i_deriv_gain_rate,
    input  wire logic signed [31:0]    i_integ_low,
    input  wire logic signed [31:0]    i_integ_high,
    input  wire logic signed [15:0]    i_err,
    input  wire logic signed [31:0]    i_row  [tapm_pkg::N_AXES],
    input  wire logic signed [31:0]    i_sums [tapm_pkg::N_AXES],
    output logic                       o_inside,
    output logic signed [31:0]         o_sum,
    output logic signed [31:0]         o_moment
);

    localparam int PW = tapm_pkg::PID_W;
    localparam int MW = tapm_pkg::MAC_W;
    localparam logic signed [MW-1:0] SAT_HI = {{(MW-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [MW-1:0] SAT_LO = {{(MW-31){1'b1}}, {31{1'b0}}};

    function automatic logic signed [31:0] sat32(input logic signed [MW-1:0] x);
        logic signed [31:0] res;
        if (x > SAT_HI) begin
            res = 32'sh7fff_ffff;
        end else if (x < SAT_LO) begin
            res = 32'sh8000_0000;
        end else begin
            res = $signed(x[31:0]);
        end
        return res;
    endfunction

    logic signed [15:0]    r_err;
    logic signed [15:0]    r_last;
    logic signed [31:0]    r_row [tapm_pkg::N_AXES];
    logic signed [MW-1:0]  r_prod;
    logic signed [PW-1:0]  r_cand;
    logic                  r_inside;
    logic signed [PW-1:0]  r_p;
    logic signed [31:0]    r_acc;
    logic signed [31:0]    r_s;
    logic signed [MW-1:0]  r_macc;

    logic signed [32:0]    w_mul_a;
    logic signed [32:0]    w_mul_b;
    logic                  w_mul_en;
    logic signed [MW-1:0]  w_prod;
    logic signed [16:0]    w_diff;
    logic signed [MW-1:0]  w_sh_err;
    logic signed [PW-1:0]  w_term;
    logic signed [PW-1:0]  w_acc_x;
    logic signed [PW-1:0]  w_cand;
    logic signed [PW-1:0]  w_low_x;
    logic signed [PW-1:0]  w_high_x;
    logic signed [PW-1:0]  w_pid;
    logic signed [MW-1:0]  w_sh_frac;
    logic signed [MW-1:0]  w_mac;
    logic signed [MW-1:0]  w_neg;

    assign w_diff = {r_err[15], r_err} - {r_last[15], r_last};

    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b1;
        case (i_ctl.phase)
            tapm_pkg::PH_INT: begin
                w_mul_a = {1'b0, i_integ_gain_step};
                w_mul_b = {{17{r_err[15]}}, r_err};
            end
            tapm_pkg::PH_PROP: begin
                w_mul_a = {1'b0, i_prop_gain};
                w_mul_b = {{17{r_err[15]}}, r_err};
            end
            tapm_pkg::PH_DER: begin
                w_mul_a = {1'b0, i_deriv_gain_rate};
                w_mul_b = {{16{w_diff[16]}}, w_diff};
            end
            tapm_pkg::PH_ROW0: begin
                w_mul_a = {r_row[0][31], r_row[0]};
                w_mul_b = {i_sums[0][31], i_sums[0]};
            end
            tapm_pkg::PH_ROW1: begin
                w_mul_a = {r_row[1][31], r_row[1]};
                w_mul_b = {i_sums[1][31], i_sums[1]};
            end
            tapm_pkg::PH_ROW2: begin
                w_mul_a = {r_row[2][31], r_row[2]};
                w_mul_b = {i_sums[2][31], i_sums[2]};
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // gain times q1.15 error, floored back to q16.16
    assign w_sh_err = r_prod >>> tapm_pkg::ERR_FRAC;
    assign w_term   = $signed(w_sh_err[PW-1:0]);
    assign w_acc_x  = {{(PW-32){r_acc[31]}}, r_acc};
    assign w_cand   = w_acc_x + w_term;
    assign w_low_x  = {{(PW-32){i_integ_low[31]}}, i_integ_low};
    assign w_high_x = {{(PW-32){i_integ_high[31]}}, i_integ_high};
    assign w_pid    = r_p + w_acc_x + w_term;

    assign w_sh_frac = r_prod >>> FRAC_BITS;
    assign w_mac     = r_macc + w_sh_frac;
    assign w_neg     = -w_mac;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_err <= i_err;
            r_row <= i_row;
        end
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        if (i_ctl.phase == tapm_pkg::PH_PROP) begin
            r_cand <= w_cand;
        end
        if (i_ctl.phase == tapm_pkg::PH_DER) begin
            r_p <= w_term;
        end
        if (i_ctl.phase == tapm_pkg::PH_SUM) begin
            r_s <= sat32({{(MW-PW){w_pid[PW-1]}}, w_pid});
        end
        if (i_ctl.phase == tapm_pkg::PH_ROW1) begin
            r_macc <= w_sh_frac;
        end
        if (i_ctl.phase == tapm_pkg::PH_ROW2) begin
            r_macc <= w_mac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_acc    <= '0;
            r_inside <= 1'b0;
        end else begin
            if (i_ctl.phase == tapm_pkg::PH_PROP) begin
                r_inside <= (w_cand > w_low_x) && (w_cand < w_high_x);
            end
            // candidate lies inside the limits, so it fits 32 bits
            if (i_ctl.phase == tapm_pkg::PH_DER && i_ctl.commit) begin
                r_acc <= $signed(r_cand[31:0]);
            end
            if (i_ctl.phase == tapm_pkg::PH_SUM) begin
                r_last <= r_err;
            end
        end
    end

    assign o_inside = r_inside;
    assign o_sum    = r_s;
    assign o_moment = sat32(w_neg);

endmodule

`default_nettype wire

FILE: rtl/tapm_merge.sv
// ----------------------------------------------------------------------------
// tapm_merge
// combines lane results: shared anti-windup decision and the output
// register for the three moments
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tapm_merge (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_inside [tapm_pkg::N_AXES],
    input  wire logic signed [31:0]    i_moment [tapm_pkg::N_AXES],
    input  wire logic                  i_fin,
    input  wire logic                  i_out_stall,
    output logic                       o_commit,
    output logic                       o_take,
    output logic                       o_out_valid,
    output logic signed [31:0]         o_moment_x,
    output logic signed [31:0]         o_moment_y,
    output logic signed [31:0]         o_moment_z
);

    logic               r_out_valid;
    logic signed [31:0] r_mom [tapm_pkg::N_AXES];

    // integrator moves only when every axis stays inside the limits
    always_comb begin
        o_commit = 1'b1;
        for (int k = 0; k < tapm_pkg::N_AXES; k++) begin
            o_commit = o_commit & i_inside[k];
        end
    end

    assign o_take = i_fin && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_mom <= i_moment;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_moment_x  = r_mom[0];
    assign o_moment_y  = r_mom[1];
    assign o_moment_z  = r_mom[2];

endmodule

`default_nettype wire

FILE: rtl/three_axis_pid_inertia_moment_core.sv
// ----------------------------------------------------------------------------
// three_axis_pid_inertia_moment_core
// three-axis pid with shared-limit anti-windup and inertia matrix output
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_in_valid / o_in_stall) takes one attitude error and one
//   inertia matrix per transaction. output channel (o_out_valid / i_out_stall)
//   returns one moment vector per input transaction.
//   config channel (i_cfg_valid / o_cfg_ready) writes gains and limits; ready
//   is always high, write only while the core is idle.
//   three axis lanes run in parallel, each with one 33x33 multiplier that is
//   used six times per transaction (i, p, d terms, then its matrix row).
//   the lanes step through the int, prop, der, sum and row phases, and the
//   output register takes the moments in fin; a new transaction is taken
//   only in idle, and o_in_stall is high while a transaction is in the lanes.
//   a stalled output holds its moments; the core finishes the next
//   transaction and waits for the output register before going idle.
//   reset: gains, limits, integrators and previous errors return to their
//   reset values; the integrator clear is done by reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "three_axis_pid_inertia_moment_core_assert.svh"

module three_axis_pid_inertia_moment_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic signed [15:0]                i_err_x,
    input  wire logic signed [15:0]                i_err_y,
    input  wire logic signed [15:0]                i_err_z,
    input  wire logic signed [31:0]                i_inertia_xx,
    input  wire logic signed [31:0]                i_inertia_xy,
    input  wire logic signed [31:0]                i_inertia_xz,
    input  wire logic signed [31:0]                i_inertia_yx,
    input  wire logic signed [31:0]                i_inertia_yy,
    input  wire logic signed [31:0]                i_inertia_yz,
    input  wire logic signed [31:0]                i_inertia_zx,
    input  wire logic signed [31:0]                i_inertia_zy,
    input  wire logic signed [31:0]                i_inertia_zz,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic signed [31:0]                     o_moment_x,
    output logic signed [31:0]                     o_moment_y,
    output logic signed [31:0]                     o_moment_z,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tapm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [31:0]                       i_cfg_data
);

    localparam logic [31:0] ONE_Q = 32'd1 << FRAC_BITS;

    logic [31:0]        r_prop_gain;
    logic [31:0]        r_integ_gain_step;
    logic [31:0]        r_deriv_gain_rate;
    logic signed [31:0] r_integ_low;
    logic signed [31:0] r_integ_high;

    tapm_pkg::t_phase    w_phase;
    tapm_pkg::t_lane_ctl w_ctl;
    logic                w_load;
    logic                w_take;
    logic                w_commit;
    logic                w_in_accept;

    logic signed [15:0] w_err     [tapm_pkg::N_AXES];
    logic signed [31:0] w_inertia [tapm_pkg::N_AXES][tapm_pkg::N_AXES];
    logic               w_inside  [tapm_pkg::N_AXES];
    logic signed [31:0] w_sums    [tapm_pkg::N_AXES];
    logic signed [31:0] w_moment  [tapm_pkg::N_AXES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain       <= ONE_Q;
            r_integ_gain_step <= '0;
            r_deriv_gain_rate <= '0;
            r_integ_low       <= $signed(-ONE_Q);
            r_integ_high      <= $signed(ONE_Q);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tapm_pkg::CFG_PROP_GAIN:       r_prop_gain       <= i_cfg_data;
                tapm_pkg::CFG_INTEG_GAIN_STEP: r_integ_gain_step <= i_cfg_data;
                tapm_pkg::CFG_DERIV_GAIN_RATE: r_deriv_gain_rate <= i_cfg_data;
                tapm_pkg::CFG_INTEG_LOW:       r_integ_low       <= $signed(i_cfg_data);
                tapm_pkg::CFG_INTEG_HIGH:      r_integ_high      <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign w_err[0] = i_err_x;
    assign w_err[1] = i_err_y;
    assign w_err[2] = i_err_z;

    assign w_inertia[0][0] = i_inertia_xx;
    assign w_inertia[0][1] = i_inertia_xy;
    assign w_inertia[0][2] = i_inertia_xz;
    assign w_inertia[1][0] = i_inertia_yx;
    assign w_inertia[1][1] = i_inertia_yy;
    assign w_inertia[1][2] = i_inertia_yz;
    assign w_inertia[2][0] = i_inertia_zx;
    assign w_inertia[2][1] = i_inertia_zy;
    assign w_inertia[2][2] = i_inertia_zz;

    tapm_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_take     (w_take),
        .o_phase    (w_phase),
        .o_load     (w_load),
        .o_in_stall (o_in_stall)
    );

    assign w_ctl.phase  = w_phase;
    assign w_ctl.load   = w_load;
    assign w_ctl.commit = w_commit;

    for (genvar g = 0; g < tapm_pkg::N_AXES; g++) begin : g_lane
        tapm_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk             (i_clk),
            .i_rst_n           (i_rst_n),
            .i_ctl             (w_ctl),
            .i_prop_gain       (r_prop_gain),
            .i_integ_gain_step (r_integ_gain_step),
            .i_deriv_gain_rate (r_deriv_gain_rate),
            .i_integ_low       (r_integ_low),
            .i_integ_high      (r_integ_high),
            .i_err             (w_err[g]),
            .i_row             (w_inertia[g]),
            .i_sums            (w_sums),
            .o_inside          (w_inside[g]),
            .o_sum             (w_sums[g]),
            .o_moment          (w_moment[g])
        );
    end

    tapm_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_inside    (w_inside),
        .i_moment    (w_moment),
        .i_fin       (w_phase == tapm_pkg::PH_FIN),
        .i_out_stall (i_out_stall),
        .o_commit    (w_commit),
        .o_take      (w_take),
        .o_out_valid (o_out_valid),
        .o_moment_x  (o_moment_x),
        .o_moment_y  (o_moment_y),
        .o_moment_z  (o_moment_z)
    );

    assign w_in_accept = i_in_valid && !o_in_stall;

    `TAPM_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, w_in_accept, w_phase == tapm_pkg::PH_INT)
    `TAPM_ASSERT_IMP(a_valid_from_fin, i_clk, i_rst_n, $rose(o_out_valid), $past(w_phase) == tapm_pkg::PH_FIN)
    `TAPM_ASSERT_NXT(a_fin_waits, i_clk, i_rst_n, (w_phase == tapm_pkg::PH_FIN) && o_out_valid && i_out_stall, w_phase == tapm_pkg::PH_FIN)

endmodule

`default_nettype wire
